// ===== rtl/stkr_pkg.sv =====
package stkr_pkg;

	// fixed field widths
	localparam int unsigned COUNT_W   = 16;
	localparam int unsigned BIT_IDX_W = 5;
	localparam int unsigned CODE_W    = 5;
	localparam int unsigned CFG_IDX_W = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_START_WAIT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 2'd1;

	// register reset values
	localparam logic [COUNT_W-1:0] START_WAIT_RST  = 16'd10;
	localparam logic [COUNT_W-1:0] HALF_PERIOD_RST = 16'd2;

endpackage

// ===== rtl/stkr_key_decode.sv =====
module stkr_key_decode import stkr_pkg::*; #(
	parameter int unsigned FRAME_BITS = 16
) (
	input  logic [FRAME_BITS-1:0] frame,
	output logic                  drop,
	output logic [CODE_W-1:0]     code
);

	// frame with only its top bit set is discarded
	assign drop = (frame == (FRAME_BITS'(1) << (FRAME_BITS - 1)));

	// one-hot frame maps to bit position plus one, anything else to zero
	always_comb begin
		code = '0;
		for (int i = 0; i < FRAME_BITS; i++) begin
			if (frame == (FRAME_BITS'(1) << i)) begin
				code = CODE_W'(i + 1);
			end
		end
	end

endmodule

// ===== rtl/serial_touch_key_reader_unit.sv =====
// a tick beat accepted into the input register loads the result register once that
// register is free or being drained, so a stall can hold it in between
// (one input register stage, one result register stage)
// throughput: one tick beat per cycle, sustained, with out_ready held high
// reset: arst_n low clears the reader to idle, the registers to 10 and 2 wait/half
// ticks, and drops any beat in flight
module serial_touch_key_reader_unit import stkr_pkg::*; #(
	parameter int unsigned FRAME_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// tick channel
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 data_level,
	// result channel
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 clock_level,
	output logic                 key_valid,
	output logic [CODE_W-1:0]    key_code,
	// register write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COUNT_W-1:0]   cfg_data
);

	localparam int unsigned IDX_W = $clog2(FRAME_BITS);
	localparam logic [BIT_IDX_W-1:0] FRAME_BITS_N = BIT_IDX_W'(FRAME_BITS);

	// reader phases
	typedef enum logic [1:0] {
		PH_IDLE,
		PH_WAIT,
		PH_HIGH,
		PH_LOW
	} phase_t;

	// configuration registers
	logic [COUNT_W-1:0] start_wait_q;
	logic [COUNT_W-1:0] half_period_q;

	// input stage
	logic valid_s1;
	logic data_s1;

	// reader state
	phase_t                phase_q;
	logic [COUNT_W-1:0]    tick_q;
	logic [BIT_IDX_W-1:0]  bit_idx_q;
	logic [FRAME_BITS-1:0] frame_q;
	logic                  last_data_q;

	// result register
	logic              out_valid_q;
	logic              clock_level_q;
	logic              key_valid_q;
	logic [CODE_W-1:0] key_code_q;

	// next-state logic
	phase_t                phase_n;
	logic [COUNT_W-1:0]    tick_n;
	logic [COUNT_W-1:0]    tick_inc;
	logic [BIT_IDX_W-1:0]  bit_idx_n;
	logic [BIT_IDX_W-1:0]  bit_inc;
	logic [FRAME_BITS-1:0] frame_n;
	logic [COUNT_W-1:0]    half;
	logic                  clock_n;
	logic                  key_valid_n;
	logic                  drop;
	logic [CODE_W-1:0]     code;
	logic                  advance;

	// handshake: the input stage moves on whenever the result register is free
	// or being drained this cycle, so a full pipe still takes a beat a cycle while out_ready is high
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	assign out_valid   = out_valid_q;
	assign clock_level = clock_level_q;
	assign key_valid   = key_valid_q;
	assign key_code    = key_code_q;

	// register writes, unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_wait_q  <= START_WAIT_RST;
			half_period_q <= HALF_PERIOD_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_START_WAIT) begin
				start_wait_q <= cfg_data;
			end else if (cfg_index == CFG_HALF_PERIOD) begin
				half_period_q <= cfg_data;
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			data_s1  <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
			data_s1  <= data_level;
		end
	end

	// decode of the frame as it stands when the last low half ends
	stkr_key_decode #(
		.FRAME_BITS(FRAME_BITS)
	) u_decode (
		.frame(frame_q),
		.drop (drop),
		.code (code)
	);

	// a zero half period behaves as one tick
	assign half     = (half_period_q == '0) ? COUNT_W'(1) : half_period_q;
	assign tick_inc = tick_q + COUNT_W'(1);
	assign bit_inc  = bit_idx_q + BIT_IDX_W'(1);

	// one tick of the reader; a wait or low half that ends this tick falls
	// through into the high half on the same tick
	always_comb begin
		phase_n     = phase_q;
		tick_n      = tick_q;
		bit_idx_n   = bit_idx_q;
		frame_n     = frame_q;
		clock_n     = 1'b0;
		key_valid_n = 1'b0;
		unique case (phase_q)
			PH_IDLE: begin
				// falling edge of the data line opens a frame
				if (last_data_q && !data_s1) begin
					phase_n   = PH_WAIT;
					tick_n    = '0;
					bit_idx_n = '0;
					frame_n   = '0;
				end
			end
			PH_WAIT: begin
				if (tick_q >= start_wait_q) begin
					phase_n = PH_HIGH;
					tick_n  = '0;
				end else begin
					tick_n = tick_inc;
				end
			end
			PH_LOW: begin
				if (tick_inc >= half) begin
					tick_n = '0;
					if (bit_inc >= FRAME_BITS_N) begin
						// end of frame
						phase_n     = PH_IDLE;
						bit_idx_n   = '0;
						key_valid_n = !drop;
					end else begin
						phase_n   = PH_HIGH;
						bit_idx_n = bit_inc;
					end
				end else begin
					tick_n = tick_inc;
				end
			end
			PH_HIGH: begin
				// handled below together with the fall-through cases
			end
			default: begin
			end
		endcase
		if (phase_n == PH_HIGH) begin
			clock_n = 1'b1;
			tick_n  = tick_n + COUNT_W'(1);
			if (tick_n >= half) begin
				// sample on the last high tick
				if (data_s1 && (bit_idx_n < FRAME_BITS_N)) begin
					frame_n[bit_idx_n[IDX_W-1:0]] = 1'b1;
				end
				phase_n = PH_LOW;
				tick_n  = '0;
			end
		end
	end

	// reader state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			tick_q        <= '0;
			bit_idx_q     <= '0;
			frame_q       <= '0;
			last_data_q   <= 1'b0;
			out_valid_q   <= 1'b0;
			clock_level_q <= 1'b0;
			key_valid_q   <= 1'b0;
			key_code_q    <= '0;
		end else begin
			if (advance) begin
				phase_q       <= phase_n;
				tick_q        <= tick_n;
				bit_idx_q     <= bit_idx_n;
				frame_q       <= frame_n;
				last_data_q   <= data_s1;
				out_valid_q   <= 1'b1;
				clock_level_q <= clock_n;
				key_valid_q   <= key_valid_n;
				key_code_q    <= key_valid_n ? code : '0;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// a key is only reported on a tick with the clock line low
	a_key_clock_low: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && key_valid_q) |-> !clock_level_q)
		else $error("key reported with clock high");

	// no code without a valid key
	a_code_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!key_valid_q |-> (key_code_q == '0))
		else $error("key code set without key valid");

	// code never beyond the frame length
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		key_code_q <= CODE_W'(FRAME_BITS))
		else $error("key code out of range");

	// bit position always inside the frame, and cleared while idle
	a_bit_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_idx_q < FRAME_BITS_N)
		else $error("bit index out of range");

	a_idle_bit: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) |-> (bit_idx_q == '0))
		else $error("bit index not cleared in idle");

endmodule

// ===== dv/serial_touch_key_reader_unit_tb.sv =====
`timescale 1ns / 1ps

module serial_touch_key_reader_unit_tb;
	import stkr_pkg::*;

	localparam int unsigned FRAME_BITS = 16;
	// a frame with only its top bit set is swallowed by the reader
	localparam logic [FRAME_BITS-1:0] DROP_FRAME = FRAME_BITS'(1) << (FRAME_BITS - 1);
	// index with no register behind it, writes must change nothing
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 300000;
	localparam int unsigned RANDOM_TICKS = 220;
	localparam int unsigned NO_LIMIT = 1 << 30;

	typedef enum logic [1:0] {PH_IDLE, PH_WAIT, PH_HIGH, PH_LOW} reader_phase_t;

	typedef struct packed {
		reader_phase_t            phase;
		logic [COUNT_W-1:0]       ticks;
		logic [BIT_IDX_W-1:0]     bit_idx;
		logic [FRAME_BITS-1:0]    frame;
		logic                     last_level;
	} reader_state_t;

	// one result beat, field order matches the port concatenation below
	typedef struct packed {
		logic              clock_level;
		logic              key_valid;
		logic [CODE_W-1:0] key_code;
	} key_beat_t;

	// tracks the reader tick by tick and holds the result beats still due
	class key_frame_tracker;
		reader_state_t      st;
		logic [COUNT_W-1:0] wait_ticks;
		logic [COUNT_W-1:0] half_ticks;
		key_beat_t          due_beats[$];
		int unsigned        errors;
		int unsigned        ticks_taken;
		int unsigned        beats_seen;
		int unsigned        keys_out;
		int unsigned        frames_dropped;

		function new();
			st = '0;
			st.phase = PH_IDLE;
			wait_ticks = START_WAIT_RST;
			half_ticks = HALF_PERIOD_RST;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [COUNT_W-1:0] data);
			case (idx)
				CFG_START_WAIT: wait_ticks = data;
				CFG_HALF_PERIOD: half_ticks = data;
				default: ;
			endcase
		endfunction

		// one timebase tick of the reader
		function void advance(inout reader_state_t s, input logic d, output key_beat_t r,
			output bit sampled, output int unsigned samp_idx);
			logic [COUNT_W-1:0] half;
			half = (half_ticks == 0) ? COUNT_W'(1) : half_ticks;
			r = '0;
			sampled = 1'b0;
			samp_idx = 0;
			case (s.phase)
				PH_IDLE: begin
					if (s.last_level && !d) begin
						s.phase = PH_WAIT;
						s.ticks = '0;
						s.bit_idx = '0;
						s.frame = '0;
					end
				end
				PH_WAIT: begin
					if (s.ticks >= wait_ticks) begin
						s.phase = PH_HIGH;
						s.ticks = '0;
					end else
						s.ticks = s.ticks + 1'b1;
				end
				PH_LOW: begin
					s.ticks = s.ticks + 1'b1;
					if (s.ticks >= half) begin
						s.ticks = '0;
						s.bit_idx = s.bit_idx + 1'b1;
						if (s.bit_idx >= FRAME_BITS) begin
							s.phase = PH_IDLE;
							s.bit_idx = '0;
							if (s.frame != DROP_FRAME) begin
								r.key_valid = 1'b1;
								for (int n = 0; n < FRAME_BITS; n++)
									if (s.frame == (FRAME_BITS'(1) << n))
										r.key_code = CODE_W'(n + 1);
							end
						end else
							s.phase = PH_HIGH;
					end
				end
				default: ;
			endcase
			// a wait or low half ending this tick already counts as a high tick
			if (s.phase == PH_HIGH && !r.key_valid) begin
				r.clock_level = 1'b1;
				s.ticks = s.ticks + 1'b1;
				if (s.ticks >= half) begin
					if (s.bit_idx < FRAME_BITS) begin
						sampled = 1'b1;
						samp_idx = 32'(s.bit_idx);
						if (d)
							s.frame[s.bit_idx] = 1'b1;
					end
					s.phase = PH_LOW;
					s.ticks = '0;
				end
			end
			s.last_level = d;
		endfunction

		// tells whether the next tick samples the data line, and which bit
		function bit peek_sample(output int unsigned idx);
			reader_state_t s;
			key_beat_t     r;
			bit            hit;
			s = st;
			advance(s, 1'b1, r, hit, idx);
			return hit;
		endfunction

		function void take_tick(logic d);
			key_beat_t     r;
			bit            hit;
			int unsigned   idx;
			reader_phase_t was;
			was = st.phase;
			advance(st, d, r, hit, idx);
			due_beats.push_back(r);
			ticks_taken++;
			if (r.key_valid)
				keys_out++;
			else if (was == PH_LOW && st.phase == PH_IDLE)
				frames_dropped++;
		endfunction

		task report_mismatch(string what);
			$display("MISMATCH at %0t: %s", $time, what);
			errors++;
		endtask

		task match_beat(key_beat_t got);
			key_beat_t want;
			if (due_beats.size() == 0) begin
				report_mismatch("result beat with nothing outstanding");
				return;
			end
			want = due_beats.pop_front();
			if (got.clock_level !== want.clock_level)
				report_mismatch($sformatf("beat %0d clock_level got %b want %b",
					beats_seen, got.clock_level, want.clock_level));
			if (got.key_valid !== want.key_valid)
				report_mismatch($sformatf("beat %0d key_valid got %b want %b",
					beats_seen, got.key_valid, want.key_valid));
			if (got.key_code !== want.key_code)
				report_mismatch($sformatf("beat %0d key_code got %0d want %0d",
					beats_seen, got.key_code, want.key_code));
			beats_seen++;
		endtask

		task close_out();
			if (due_beats.size() != 0)
				report_mismatch($sformatf("%0d result beats never arrived", due_beats.size()));
		endtask
	endclass

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic                 data_level = 1'b0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 clock_level;
	logic                 key_valid;
	logic [CODE_W-1:0]    key_code;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [COUNT_W-1:0]   cfg_data = '0;

	// while set, neither side idles or stalls
	bit          calm = 1'b0;
	int unsigned cycles = 0;
	int unsigned reg_writes = 0;
	int unsigned frames_run = 0;

	key_frame_tracker tracker = new();

	serial_touch_key_reader_unit #(
		.FRAME_BITS(FRAME_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_level(data_level),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.clock_level(clock_level),
		.key_valid(key_valid),
		.key_code(key_code),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side: random stalls with a chance of about 9 percent
	always @(negedge clk) begin
		out_ready <= calm || ($urandom_range(0, 99) >= 9);
	end

	// every accepted result beat is checked against the oldest one due
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tracker.match_beat({clock_level, key_valid, key_code});
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("DONE: errors detected");
			$finish;
		end
	end

	// one tick beat, with an optional random gap ahead of it; the tracker
	// takes the tick right here so that stimulus never races the monitor
	task automatic send_tick(logic d);
		@(negedge clk);
		while (!calm && $urandom_range(0, 99) < 9) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		data_level <= d;
		do
			@(posedge clk);
		while (!in_ready);
		tracker.take_tick(d);
	endtask

	// hold off the tick channel until every result due has come back
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (tracker.due_beats.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COUNT_W-1:0] data);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		tracker.set_reg(idx, data);
		reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// finish any frame in progress with noise, then hold the line high for a
	// while and let it fall to start a new frame
	task automatic open_frame();
		while (tracker.st.phase != PH_IDLE)
			send_tick(1'($urandom_range(0, 1)));
		while (tracker.st.phase == PH_IDLE)
			send_tick(!(tracker.st.last_level && $urandom_range(0, 3) == 0));
		frames_run++;
	endtask

	// clock out a frame: sampled ticks carry the target bit, all other ticks
	// carry random levels, which also puts ignored edges inside the frame
	task automatic clock_frame(logic [FRAME_BITS-1:0] target, int unsigned max_ticks);
		int unsigned idx;
		int unsigned n;
		logic        d;
		n = 0;
		while (tracker.st.phase != PH_IDLE && n < max_ticks) begin
			if (tracker.peek_sample(idx))
				d = target[idx];
			else
				d = 1'($urandom_range(0, 1));
			send_tick(d);
			n++;
		end
	endtask

	task automatic run_frame(logic [FRAME_BITS-1:0] target);
		open_frame();
		clock_frame(target, NO_LIMIT);
	endtask

	task automatic random_config();
		logic [COUNT_W-1:0] w;
		case ($urandom_range(0, 4))
			0: w = '0;
			1: w = COUNT_W'(1);
			2: w = COUNT_W'(2);
			3: w = COUNT_W'($urandom_range(3, 12));
			default: w = COUNT_W'($urandom_range(13, 40));
		endcase
		if ($urandom_range(0, 3) != 0)
			write_reg(CFG_START_WAIT, w);
		if ($urandom_range(0, 3) != 0)
			write_reg(CFG_HALF_PERIOD, COUNT_W'($urandom_range(0, 3)));
	endtask

	initial begin
		int unsigned             t0;
		int unsigned             frame_no;
		logic [FRAME_BITS-1:0]   target;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: reset settings, lowest key
		run_frame(16'h0001);

		// zero wait, shortest half: dropped frame, empty frame, several keys,
		// a key next to the top bit, all keys
		write_reg(CFG_START_WAIT, 16'd0);
		write_reg(CFG_HALF_PERIOD, 16'd1);
		run_frame(DROP_FRAME);
		run_frame(16'h0000);
		run_frame(16'h8001);
		run_frame(16'h4000);
		run_frame(16'hFFFF);

		// a zero half period behaves as one tick
		write_reg(CFG_HALF_PERIOD, 16'd0);
		run_frame(16'h0100);

		// both registers at their top value, then pulled down mid frame: a
		// count already past the new value ends its wait or half at once
		write_reg(CFG_START_WAIT, 16'hFFFF);
		write_reg(CFG_HALF_PERIOD, 16'hFFFF);
		open_frame();
		clock_frame(16'h0004, 30);
		write_reg(CFG_START_WAIT, 16'd0);
		clock_frame(16'h0004, 30);
		write_reg(CFG_HALF_PERIOD, 16'd1);
		clock_frame(16'h0004, NO_LIMIT);

		// a write to the spare index must leave both registers alone
		write_reg(CFG_UNUSED, 16'hFFFF);
		write_reg(CFG_UNUSED, COUNT_W'($urandom_range(0, 65535)));
		run_frame(16'h0020);

		// random part: mostly well-formed frames with random content
		t0 = tracker.ticks_taken;
		frame_no = 0;
		while (tracker.ticks_taken - t0 < RANDOM_TICKS) begin
			calm = (tracker.ticks_taken - t0 >= 60) && (tracker.ticks_taken - t0 < 180);
			if (frame_no % 4 == 0)
				random_config();
			case ($urandom_range(0, 19))
				0, 1: target = DROP_FRAME;
				2, 3: target = '0;
				4: target = '1;
				5, 6, 7: target = FRAME_BITS'($urandom_range(0, 65535));
				default: target = FRAME_BITS'(1) << $urandom_range(0, FRAME_BITS - 1);
			endcase
			if ($urandom_range(0, 6) == 0) begin
				// noise: random levels, may start and cut frames anywhere
				repeat ($urandom_range(5, 40))
					send_tick(1'($urandom_range(0, 1)));
			end else if ($urandom_range(0, 9) == 0) begin
				// register change in the middle of a frame
				open_frame();
				clock_frame(target, $urandom_range(1, 30));
				if ($urandom_range(0, 1))
					write_reg(CFG_START_WAIT, COUNT_W'($urandom_range(0, 6)));
				else
					write_reg(CFG_HALF_PERIOD, COUNT_W'($urandom_range(0, 3)));
				clock_frame(target, NO_LIMIT);
			end else
				run_frame(target);
			frame_no++;
		end
		calm = 1'b0;

		// let everything come back, then wait on for stray beats
		drain();
		repeat (20) @(posedge clk);
		tracker.close_out();

		$display("covered %0d ticks over %0d frames: %0d key codes, %0d dropped frames",
			tracker.ticks_taken, frames_run, tracker.keys_out, tracker.frames_dropped);
		$display("%0d register writes incl. extremes and mid-frame changes, %0d beats checked",
			reg_writes, tracker.beats_seen);
		if (tracker.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/stkr_pkg.sv
rtl/stkr_key_decode.sv
rtl/serial_touch_key_reader_unit.sv
dv/serial_touch_key_reader_unit_tb.sv
